[design/mbps_pkg.sv]
package mbps_pkg;

  // Default sizing of the scanner
  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Pattern bytes that have a register; higher positions are wildcards
  localparam int PAT_REG_BYTES = 16;
  // Index width able to name any pattern position up to the largest window
  localparam int IDX_W = 7;

  // Transaction queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ONLY   = 3'd4;

  // Result kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] care_mask;
    logic [4:0]  pattern_length;
    logic        first_only;
  } cfg_t;

  // One classified byte: a match result, an end result, or both
  typedef struct packed {
    logic        has_match;
    logic        has_end;
    logic [31:0] offset;
    logic [31:0] count;
  } entry_t;

endpackage

[design/mbps_if.sv]
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] offset;
  logic [31:0] match_count;
  logic        last;

  modport source (output valid, output kind, output offset, output match_count,
                  output last, input ready);
  modport sink (input valid, input kind, input offset, input match_count,
                input last, output ready);
endinterface

[design/mbps_front.sv]
module mbps_front #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mbps_pkg::cfg_t   cfg,
  mbps_in_if.sink          in_stream,
  input  logic             q_full,
  output logic             q_push,
  output mbps_pkg::entry_t q_entry
);
  import mbps_pkg::*;

  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int WIDE_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  logic [7:0]             window_r   [PATTERN_MAX];
  logic [7:0]             window_nxt [PATTERN_MAX];
  logic [7:0]             pat_bytes  [PAT_REG_BYTES];
  logic [127:0]           pat_all;
  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0] off_n;
  logic [WIDE_W-1:0]      off_w;
  logic [31:0]            matches_r;
  logic [31:0]            cnt_new;
  logic                   done_r;
  logic [LEN_W-1:0]       len_n;
  logic                   hit;
  logic                   match;
  logic                   accept;
  logic                   eob;

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && in_stream.ready;
  assign eob             = in_stream.end_of_buffer;

  // Split the pattern registers into bytes
  assign pat_all = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    for (int k = 0; k < PAT_REG_BYTES; k++) begin
      pat_bytes[k] = pat_all[8*k +: 8];
    end
  end

  // Clamp the pattern length into 1..PATTERN_MAX
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      len_n = LEN_W'(1);
    end else if (32'(cfg.pattern_length) > PATTERN_MAX) begin
      len_n = LEN_W'(PATTERN_MAX);
    end else begin
      len_n = LEN_W'(cfg.pattern_length);
    end
  end

  // Shift the new byte into the window
  always_comb begin
    window_nxt[0] = in_stream.data_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      window_nxt[i] = window_r[i-1];
    end
  end

  // Compare each window byte against the pattern byte aligned to it
  always_comb begin
    logic [IDX_W-1:0] j;
    hit = 1'b1;
    j   = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (IDX_W'(i) < IDX_W'(len_n)) begin
        j = IDX_W'(len_n) - IDX_W'(i) - IDX_W'(1);
        if (j < IDX_W'(PAT_REG_BYTES)) begin
          if (cfg.care_mask[j[3:0]] && (window_nxt[i] != pat_bytes[j[3:0]])) begin
            hit = 1'b0;
          end
        end
      end
    end
  end

  // Saturating position and count
  assign pos_inc = (pos_r != '1) ? pos_r + OFFSET_BITS'(1) : pos_r;
  assign match   = (pos_inc >= OFFSET_BITS'(len_n)) && !done_r && hit;
  assign cnt_new = (match && (matches_r != '1)) ? matches_r + 32'd1 : matches_r;
  assign off_n   = pos_inc - OFFSET_BITS'(len_n);
  assign off_w   = WIDE_W'(off_n);

  // Hand a transaction to the queue when the byte causes any result
  assign q_push            = accept && (match || eob);
  assign q_entry.has_match = match;
  assign q_entry.has_end   = eob;
  assign q_entry.offset    = off_w[31:0];
  assign q_entry.count     = cnt_new;

  // Advance the scan state; clear it at the end of a buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      matches_r <= '0;
      done_r    <= 1'b0;
    end else if (accept) begin
      if (eob) begin
        pos_r     <= '0;
        matches_r <= '0;
        done_r    <= 1'b0;
      end else begin
        pos_r     <= pos_inc;
        matches_r <= cnt_new;
        done_r    <= done_r || (match && cfg.first_only);
      end
    end
  end

  // Window bytes older than the buffer are never compared
  always_ff @(posedge clk) begin
    if (accept) begin
      window_r <= window_nxt;
    end
  end

endmodule

[design/mbps_queue.sv]
module mbps_queue #(
  parameter int DEPTH = mbps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbps_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output mbps_pkg::entry_t head,
  output logic             empty
);
  import mbps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Move pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/mbps_back.sv]
module mbps_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  mbps_pkg::entry_t q_head,
  output logic             q_pop,
  mbps_out_if.source       out_stream
);
  import mbps_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] count_r, count_nxt;
  logic        last_r, last_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] pend_count_r, pend_count_nxt;
  logic        slot_free;

  assign slot_free              = !out_valid_r || out_stream.ready;
  assign out_stream.valid       = out_valid_r;
  assign out_stream.kind        = kind_r;
  assign out_stream.offset      = offset_r;
  assign out_stream.match_count = count_r;
  assign out_stream.last        = last_r;

  // Load the output register: an owed end result first, then the queue head
  always_comb begin
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    offset_nxt     = offset_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    pend_nxt       = pend_r;
    pend_count_nxt = pend_count_r;
    q_pop          = 1'b0;
    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_END;
        offset_nxt    = '0;
        count_nxt     = pend_count_r;
        last_nxt      = 1'b1;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        count_nxt     = q_head.count;
        if (q_head.has_match) begin
          kind_nxt       = KIND_MATCH;
          offset_nxt     = q_head.offset;
          last_nxt       = !q_head.has_end;
          pend_nxt       = q_head.has_end;
          pend_count_nxt = q_head.count;
        end else begin
          kind_nxt   = KIND_END;
          offset_nxt = '0;
          last_nxt   = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  // Hold control state under reset; payload follows without it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    offset_r     <= offset_nxt;
    count_r      <= count_nxt;
    last_r       <= last_nxt;
    pend_count_r <= pend_count_nxt;
  end

endmodule

[design/masked_byte_pattern_scanner_core.sv]
// Wildcard byte pattern scanner. Takes one byte per cycle and compares the
// last pattern_length bytes of the current buffer against the configured
// pattern, skipping positions whose care bit is clear. Each match (only the
// first per buffer if first_only is set) yields a result with its start
// offset; the byte marked end_of_buffer yields an end result with the match
// count and restarts the scan. The front stage shifts the window and does
// all byte compares in parallel; input is taken at one byte per cycle while
// the four-entry queue has room. Results go through the queue and the output
// register, leaving at one per cycle while the sink is ready; a matching
// end byte gives a match result, then an end result. Configuration must
// be written only while the block is idle; the block does not enforce it.
module masked_byte_pattern_scanner_core #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mbps_in_if.sink                         in_stream,
  mbps_out_if.source                      out_stream
);
  import mbps_pkg::*;

  cfg_t   cfg_r;
  entry_t push_entry;
  entry_t head;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.care_mask      <= '0;
      cfg_r.pattern_length <= 5'd1;
      cfg_r.first_only     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LOW:  cfg_r.pattern_low    <= cfg_wdata;
        REG_PATTERN_HIGH: cfg_r.pattern_high   <= cfg_wdata;
        REG_CARE_MASK:    cfg_r.care_mask      <= cfg_wdata[15:0];
        REG_PATTERN_LEN:  cfg_r.pattern_length <= cfg_wdata[4:0];
        REG_FIRST_ONLY:   cfg_r.first_only     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  mbps_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_stream (in_stream),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  mbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty)
  );

  mbps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
